/* src/rtg_pkg.sv */
// Shared types, constants and table functions for the Reinhard tone mapper.
// Depends on nothing; every module of the block imports it.
package rtg_pkg;

    // Word that enters the block.
    typedef struct packed {
        logic [31:0] hdr_sample;
        logic        last_in;
    } t_in_word;

    // Word that leaves the block.
    typedef struct packed {
        logic [7:0] ldr_value;
        logic       last_out;
    } t_out_word;

    // Sideband that travels with each sample through the stages.
    typedef struct packed {
        logic last;
        logic zero;
    } t_ctl;

    // Register indexes of the configuration port.
    localparam logic REG_EXPOSURE_GAIN = 1'b0;
    localparam logic REG_INVERSE_GAMMA = 1'b1;

    localparam logic [15:0] GAIN_RESET = 16'd256;
    localparam logic [15:0] IGAM_RESET = 16'd1862;

    // Number of fraction bits in the log and power stages.
    localparam int EXP_FRAC_BITS = 24;
    // Integer part of the exponent at or above which the result is zero.
    localparam logic [8:0] EXP_INT_LIMIT = 9'd9;

    // Integer square root, bit by bit; used only at elaboration.
    function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] bit_v;
        x     = x_in;
        res   = '0;
        bit_v = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (x >= res + bit_v) begin
                x   = x - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // 2^(-2^-k) in Q0.30, built by repeated square roots from one half.
    function automatic logic [29:0] pow_entry(input int k);
        logic [63:0] t;
        t = 64'd1 << 29;
        for (int j = 1; j <= k; j++) begin
            t = isqrt64(t << 30);
        end
        return t[29:0];
    endfunction

endpackage

/* src/rtg_div.sv */
// Exposure multiply, normalization and pipelined restoring divide r = v / (v + 1).
// Depends on rtg_pkg for the sideband type.
module rtg_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_adv,
    input  logic         i_valid,
    input  logic [31:0]  i_sample,
    input  logic [15:0]  i_gain,
    input  logic         i_last,
    output logic         o_valid,
    output logic [29:0]  o_r,
    output rtg_pkg::t_ctl o_ctl
);
    import rtg_pkg::*;

    localparam int DIV_STEPS = 30;
    localparam logic [48:0] DEN_ONE = 49'd1 << (FRAC_BITS + 8);

    logic        r_a_valid, r_b_valid, r_c_valid;
    logic        r_a_last, r_b_last, r_c_last;
    logic [47:0] r_a_num, r_b_num, r_c_num;
    logic [48:0] r_b_den, r_c_den;
    logic [3:0]  r_c_sh;
    logic [3:0]  n_c_sh;

    logic [34:0] r_rem  [0:DIV_STEPS];
    logic [33:0] r_den  [0:DIV_STEPS];
    logic [29:0] r_q    [0:DIV_STEPS];
    logic        r_v    [0:DIV_STEPS];
    t_ctl        r_ct   [0:DIV_STEPS];

    // Valid bits of the front stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (i_adv) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    // Exposure product, then denominator, then normalizing shift amount.
    always_comb begin
        n_c_sh = '0;
        for (int i = 34; i < 49; i++) begin
            if (r_b_den[i]) n_c_sh = 4'(i - 33);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_a_num  <= 48'(i_sample) * 48'(i_gain);
            r_a_last <= i_last;
            r_b_num  <= r_a_num;
            r_b_den  <= 49'(r_a_num) + DEN_ONE;
            r_b_last <= r_a_last;
            r_c_num  <= r_b_num;
            r_c_den  <= r_b_den;
            r_c_sh   <= n_c_sh;
            r_c_last <= r_b_last;
        end
    end

    // Shift both operands so the denominator fits in 34 bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_adv) begin
            r_v[0] <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rem[0]     <= 35'(r_c_num >> r_c_sh);
            r_den[0]     <= 34'(r_c_den >> r_c_sh);
            r_q[0]       <= '0;
            r_ct[0].last <= r_c_last;
            r_ct[0].zero <= (r_c_num == '0);
        end
    end

    // One quotient bit per stage.
    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        logic [34:0] t_sh;
        logic        t_ge;
        assign t_sh = {r_rem[j][33:0], 1'b0};
        assign t_ge = (t_sh >= {1'b0, r_den[j]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j+1] <= 1'b0;
            end else if (i_adv) begin
                r_v[j+1] <= r_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem[j+1] <= t_ge ? (t_sh - {1'b0, r_den[j]}) : t_sh;
                r_den[j+1] <= r_den[j];
                r_q[j+1]   <= {r_q[j][28:0], t_ge};
                r_ct[j+1]  <= r_ct[j];
            end
        end
    end

    assign o_valid = r_v[DIV_STEPS];
    assign o_r     = r_q[DIV_STEPS];
    assign o_ctl   = r_ct[DIV_STEPS];

endmodule

/* src/rtg_log.sv */
// Base-2 logarithm of the compressed value by repeated squaring, times inverse gamma.
// Depends on rtg_pkg for the sideband type and fraction width.
module rtg_log (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  logic          i_valid,
    input  logic [29:0]   i_r,
    input  rtg_pkg::t_ctl i_ctl,
    input  logic [15:0]   i_igam,
    output logic          o_valid,
    output logic [32:0]   o_e,
    output rtg_pkg::t_ctl o_ctl
);
    import rtg_pkg::*;

    logic [4:0]  n_p;
    logic [30:0] r_m    [0:EXP_FRAC_BITS];
    logic [23:0] r_frac [0:EXP_FRAC_BITS];
    logic [4:0]  r_ip   [0:EXP_FRAC_BITS];
    logic        r_v    [0:EXP_FRAC_BITS];
    t_ctl        r_ct   [0:EXP_FRAC_BITS];

    logic        r_l_valid, r_e_valid;
    logic [28:0] r_l;
    t_ctl        r_l_ct, r_e_ct;
    logic [44:0] r_e_prod;

    // Leading one of the quotient sets the integer part of the log.
    always_comb begin
        n_p = '0;
        for (int i = 0; i < 30; i++) begin
            if (i_r[i]) n_p = 5'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_adv) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_m[0]       <= 31'(i_r) << (5'd30 - n_p);
            r_ip[0]      <= 5'd30 - n_p;
            r_frac[0]    <= '0;
            r_ct[0].last <= i_ctl.last;
            r_ct[0].zero <= i_ctl.zero | (i_r == '0);
        end
    end

    // Each stage squares the mantissa and yields one fraction bit.
    for (genvar i = 0; i < EXP_FRAC_BITS; i++) begin : g_sq
        logic [61:0] t_sq;
        logic [31:0] t_s;
        assign t_sq = 62'(r_m[i]) * 62'(r_m[i]);
        assign t_s  = t_sq[61:30];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_adv) begin
                r_v[i+1] <= r_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_m[i+1]    <= t_s[31] ? t_s[31:1] : t_s[30:0];
                r_frac[i+1] <= {r_frac[i][22:0], t_s[31]};
                r_ip[i+1]   <= r_ip[i];
                r_ct[i+1]   <= r_ct[i];
            end
        end
    end

    // Assemble -log2(r), then scale by inverse gamma.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else if (i_adv) begin
            r_l_valid <= r_v[EXP_FRAC_BITS];
            r_e_valid <= r_l_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_l      <= {r_ip[EXP_FRAC_BITS], 24'd0} - 29'(r_frac[EXP_FRAC_BITS]);
            r_l_ct   <= r_ct[EXP_FRAC_BITS];
            r_e_prod <= 45'(r_l) * 45'(i_igam);
            r_e_ct   <= r_l_ct;
        end
    end

    assign o_valid = r_e_valid;
    assign o_e     = r_e_prod[44:12];
    assign o_ctl   = r_e_ct;

endmodule

/* src/rtg_exp.sv */
// Power of two of the negated exponent by table products, then scale to 8 bits.
// Depends on rtg_pkg for the table function, the sideband and the output word.
module rtg_exp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_valid,
    input  logic [32:0]       i_e,
    input  rtg_pkg::t_ctl     i_ctl,
    input  logic              i_igam_zero,
    output logic              o_valid,
    output rtg_pkg::t_out_word o_word
);
    import rtg_pkg::*;

    localparam logic [30:0] Y_ONE = 31'd1 << 30;

    logic [30:0] r_y  [0:EXP_FRAC_BITS];
    logic [23:0] r_f  [0:EXP_FRAC_BITS];
    logic [3:0]  r_n  [0:EXP_FRAC_BITS];
    logic        r_v  [0:EXP_FRAC_BITS];
    t_ctl        r_ct [0:EXP_FRAC_BITS];

    logic        r_s_valid, r_o_valid;
    logic [30:0] r_s_y;
    t_ctl        r_s_ct;
    t_out_word   r_o_word;
    logic [38:0] t_scaled;
    logic [7:0]  t_ldr;

    // Split the exponent; a large integer part means the result is zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_adv) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_y[0]       <= Y_ONE;
            r_f[0]       <= i_e[23:0];
            r_n[0]       <= i_e[27:24];
            r_ct[0].last <= i_ctl.last;
            r_ct[0].zero <= i_ctl.zero | (i_e[32:24] >= EXP_INT_LIMIT);
        end
    end

    // One table factor per stage, taken when its exponent bit is set.
    for (genvar k = 1; k <= EXP_FRAC_BITS; k++) begin : g_pow
        localparam logic [29:0] TK = pow_entry(k);
        logic [60:0] t_prod;
        assign t_prod = 61'(r_y[k-1]) * 61'(TK);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_adv) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_y[k]  <= r_f[k-1][EXP_FRAC_BITS-k] ? t_prod[60:30] : r_y[k-1];
                r_f[k]  <= r_f[k-1];
                r_n[k]  <= r_n[k-1];
                r_ct[k] <= r_ct[k-1];
            end
        end
    end

    // Scale by 255 with truncation and saturation.
    assign t_scaled = 39'(r_s_y) * 39'(255);

    always_comb begin
        if (i_igam_zero) begin
            t_ldr = 8'd255;
        end else if (r_s_ct.zero) begin
            t_ldr = 8'd0;
        end else if (t_scaled[38]) begin
            t_ldr = 8'd255;
        end else begin
            t_ldr = t_scaled[37:30];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (i_adv) begin
            r_s_valid <= r_v[EXP_FRAC_BITS];
            r_o_valid <= r_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s_y              <= r_y[EXP_FRAC_BITS] >> r_n[EXP_FRAC_BITS];
            r_s_ct             <= r_ct[EXP_FRAC_BITS];
            r_o_word.ldr_value <= t_ldr;
            r_o_word.last_out  <= r_s_ct.last;
        end
    end

    assign o_valid = r_o_valid;
    assign o_word  = r_o_word;

endmodule

/* src/reinhard_tonemap_gamma_top.sv */
// Top level of the Reinhard tone mapper with gamma: configuration registers and flow control.
// Depends on rtg_pkg, rtg_div, rtg_log and rtg_exp.
//
//   channel   direction  handshake              payload
//   input     in         i_valid / o_stall      i_in_word  (t_in_word)
//   output    out        o_valid / i_stall      o_out_word (t_out_word)
//   config    in         i_cfg_we               i_cfg_idx, i_cfg_data
//
// One word is accepted every cycle while o_stall is low. The depth of the pipeline is set by the
// 30 quotient stages of the divider and the 24 squaring and 24 product stages.
// All stages move together; while a result waits under i_stall, the pipeline holds.
// Reset is synchronous and active low; it clears valid bits and loads the
// register reset values (gain 1.0, inverse gamma about 1/2.2).
module reinhard_tonemap_gamma_top #(
    parameter int INPUT_FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  rtg_pkg::t_in_word  i_in_word,
    output logic               o_valid,
    input  logic               i_stall,
    output rtg_pkg::t_out_word o_out_word,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [15:0]        i_cfg_data
);
    import rtg_pkg::*;

    logic [15:0] r_gain;
    logic [15:0] r_igam;
    logic        adv;

    logic        div_valid;
    logic [29:0] div_r;
    t_ctl        div_ctl;
    logic        log_valid;
    logic [32:0] log_e;
    t_ctl        log_ctl;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
            r_igam <= IGAM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_EXPOSURE_GAIN: r_gain <= i_cfg_data;
                REG_INVERSE_GAMMA: r_igam <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The whole pipeline advances unless a result is held at the output.
    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;

    rtg_div #(
        .FRAC_BITS (INPUT_FRAC_BITS)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_valid  (i_valid),
        .i_sample (i_in_word.hdr_sample),
        .i_gain   (r_gain),
        .i_last   (i_in_word.last_in),
        .o_valid  (div_valid),
        .o_r      (div_r),
        .o_ctl    (div_ctl)
    );

    rtg_log u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (div_valid),
        .i_r     (div_r),
        .i_ctl   (div_ctl),
        .i_igam  (r_igam),
        .o_valid (log_valid),
        .o_e     (log_e),
        .o_ctl   (log_ctl)
    );

    rtg_exp u_exp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_valid     (log_valid),
        .i_e         (log_e),
        .i_ctl       (log_ctl),
        .i_igam_zero (r_igam == '0),
        .o_valid     (o_valid),
        .o_word      (o_out_word)
    );

`ifndef NO_ASSERTIONS
    // A zero inverse gamma makes every result full scale.
    a_igam_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_igam == '0 |-> o_out_word.ldr_value == 8'd255)
        else $error("zero inverse gamma did not give full scale");

    // Zero exposure with a nonzero gamma gives black.
    a_gain_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_gain == '0 && r_igam != '0 |-> o_out_word.ldr_value == 8'd0)
        else $error("zero exposure did not give black");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");
`endif

endmodule

/* tb/reinhard_tonemap_gamma_top_test.sv */
// Testbench for the Reinhard tone mapper with gamma: directed and random samples,
// a bit-exact fixed-point predictor and a scoreboard. Depends on rtg_pkg and the RTL.
`timescale 1ns / 100ps

// Scoreboard: predicts each accepted sample and checks results in order.
class tonemap_scoreboard;
    logic [15:0] gain;
    logic [15:0] inv_gamma;
    logic [63:0] root_table [0:24];
    rtg_pkg::t_out_word pending_q [$];
    int error_count;

    function new();
        logic [63:0] x, res, bit_v;
        gain        = rtg_pkg::GAIN_RESET;
        inv_gamma   = rtg_pkg::IGAM_RESET;
        error_count = 0;
        root_table[0] = 64'd1 << 29;
        // Each entry is the square root of the one before it, in Q0.30.
        for (int k = 1; k <= 24; k++) begin
            x     = root_table[k - 1] << 30;
            res   = 0;
            bit_v = 64'd1 << 62;
            while (bit_v > x) bit_v = bit_v >> 2;
            while (bit_v != 0) begin
                if (x >= res + bit_v) begin
                    x   = x - (res + bit_v);
                    res = (res >> 1) + bit_v;
                end else begin
                    res = res >> 1;
                end
                bit_v = bit_v >> 2;
            end
            root_table[k] = res;
        end
    endfunction

    // Exposure, Reinhard compression, power and scaling to eight bits.
    function logic [7:0] map_sample(logic [31:0] sample);
        logic [63:0] num, den, ratio, m, frac, neg_log, expo, y, scaled, int_part;
        int p;
        if (inv_gamma == 0) return 8'd255;
        num = 64'(sample) * 64'(gain);
        if (num == 0) return 8'd0;
        den = num + (64'd1 << 24);
        while (den >= (64'd1 << 34)) begin
            num = num >> 1;
            den = den >> 1;
        end
        ratio = (num << 30) / den;
        if (ratio == 0) return 8'd0;
        if (ratio >= (64'd1 << 30)) return 8'd255;
        p = 29;
        while (p > 0 && ratio[p] == 1'b0) p--;
        m    = ratio << (30 - p);
        frac = 0;
        for (int i = 0; i < 24; i++) begin
            m    = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                m    = m >> 1;
                frac = frac | 64'd1;
            end
        end
        neg_log  = (64'(30 - p) << 24) - frac;
        expo     = (neg_log * 64'(inv_gamma)) >> 12;
        int_part = expo >> 24;
        if (int_part >= 9) return 8'd0;
        y = 64'd1 << 30;
        for (int k = 1; k <= 24; k++) begin
            if (expo[24 - k]) y = (y * root_table[k]) >> 30;
        end
        y      = y >> int_part;
        scaled = (y * 255) >> 30;
        if (scaled > 255) scaled = 255;
        return scaled[7:0];
    endfunction

    function void note_input(rtg_pkg::t_in_word w);
        rtg_pkg::t_out_word e;
        e.ldr_value = map_sample(w.hdr_sample);
        e.last_out  = w.last_in;
        pending_q   = {pending_q, e};
    endfunction

    function void check_result(rtg_pkg::t_out_word got);
        rtg_pkg::t_out_word e;
        if (pending_q.size() == 0) begin
            $error("unexpected result word %h", got);
            error_count++;
            return;
        end
        e = pending_q.pop_front();
        if (got.ldr_value !== e.ldr_value) begin
            $error("ldr_value: expected %0d, actual %0d", e.ldr_value, got.ldr_value);
            error_count++;
        end
        if (got.last_out !== e.last_out) begin
            $error("last_out: expected %0d, actual %0d", e.last_out, got.last_out);
            error_count++;
        end
    endfunction
endclass

module reinhard_tonemap_gamma_top_test;
    import rtg_pkg::*;

    localparam int LATENCY = 88;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_word  i_in_word;
    logic      o_valid;
    logic      i_stall;
    t_out_word o_out_word;
    logic      i_cfg_we;
    logic      i_cfg_idx;
    logic [15:0] i_cfg_data;

    tonemap_scoreboard board;
    bit hold_off_active;
    bit stall_enable;

    reinhard_tonemap_gamma_top u_dut (.*);

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Run limit.
    initial begin
        #20ms;
        $display("reinhard_tonemap_gamma_top_test: errors");
        $finish;
    end

    // Check every accepted result word.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) board.check_result(o_out_word);
    end

    // Receiver stall pattern, with one long hold-off early in the random part.
    initial begin
        int phase;
        i_stall = 1'b0;
        phase   = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_active) begin
                i_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off_active = 0;
                i_stall <= 1'b0;
            end else if (!stall_enable) begin
                i_stall <= 1'b0;
            end else begin
                phase = (phase + 1) % 64;
                if (phase < 20) i_stall <= 1'b0;
                else i_stall <= ($urandom_range(0, 99) < 40);
            end
        end
    end

    // Send one sample and wait until the block takes it.
    task automatic send_sample(logic [31:0] sample, logic last);
        t_in_word w;
        w.hdr_sample = sample;
        w.last_in    = last;
        i_valid   <= 1'b1;
        i_in_word <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_input(w);
    endtask

    task automatic go_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Register write, only when nothing is in flight; the write enable is dropped after the write.
    task automatic write_reg(logic idx, logic [15:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_EXPOSURE_GAIN) board.gain = value;
        else board.inv_gamma = value;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (board.pending_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    // Random sample spread over many magnitudes.
    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 255);
            1: return $urandom_range(0, 65535);
            2: return $urandom_range(0, 1 << 20);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_burst(int count);
        int sent;
        sent = 0;
        while (sent < count) begin
            int burst;
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst && sent < count; b++) begin
                send_sample(rand_sample(), 1'($urandom_range(0, 1)));
                sent++;
            end
            if ($urandom_range(0, 3) != 0) begin
                go_idle();
                repeat ($urandom_range(0, 6)) @(posedge i_clk);
            end
        end
        go_idle();
    endtask

    // Stimulus.
    initial begin
        logic [15:0] gains [0:4];
        logic [15:0] gammas [0:4];
        board           = new();
        hold_off_active = 0;
        stall_enable    = 0;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_in_word  = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_EXPOSURE_GAIN;
        i_cfg_data = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, zero, tiny, one, one half, huge and alternating bit patterns.
        send_sample(32'h0, 1'b0);
        send_sample(32'h1, 1'b1);
        send_sample(32'h0001_0000, 1'b0);
        send_sample(32'h0000_8000, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b1);
        send_sample(32'h5555_5555, 1'b0);
        send_sample(32'hAAAA_AAAA, 1'b1);
        go_idle();
        drain();
        // Large exponent and zero inverse gamma.
        write_reg(REG_INVERSE_GAMMA, 16'hFFFF);
        write_reg(REG_EXPOSURE_GAIN, 16'h0001);
        send_sample(32'h0000_0010, 1'b0);
        send_sample(32'h0001_0000, 1'b1);
        send_sample(32'hFFFF_FFFF, 1'b0);
        go_idle();
        drain();
        write_reg(REG_INVERSE_GAMMA, 16'h0000);
        write_reg(REG_EXPOSURE_GAIN, 16'h0000);
        send_sample(32'h0, 1'b0);
        send_sample(32'h1234_5678, 1'b1);
        go_idle();
        drain();
        write_reg(REG_INVERSE_GAMMA, 16'h1000);
        write_reg(REG_EXPOSURE_GAIN, 16'hFFFF);
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'h0000_0001, 1'b1);
        send_sample(32'h0000_0000, 1'b0);
        go_idle();
        drain();

        // Random phases over several register settings.
        gains  = '{16'd256, 16'hFFFF, 16'd1, 16'd0, 16'd4096};
        gammas = '{16'd1862, 16'd1, 16'hFFFF, 16'd4096, 16'd2731};
        stall_enable = 1;
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(REG_EXPOSURE_GAIN, ph == 4 ? 16'($urandom) : gains[ph]);
            write_reg(REG_INVERSE_GAMMA, gammas[ph]);
            if (ph == 1) hold_off_active = 1;
            random_burst(100);
            drain();
        end

        if (board.error_count == 0) begin
            $display("reinhard_tonemap_gamma_top_test: clean");
        end else begin
            $display("reinhard_tonemap_gamma_top_test: errors");
        end
        $finish;
    end
endmodule

/* files.f */
src/rtg_pkg.sv
src/rtg_div.sv
src/rtg_log.sv
src/rtg_exp.sv
src/reinhard_tonemap_gamma_top.sv
tb/reinhard_tonemap_gamma_top_test.sv
